>>> hdl/pbsl_pkg.sv
`timescale 1ns / 1ps

package pbsl_pkg;

   localparam int PT_W     = 16;
   localparam int ANG_PT_W = 15;
   localparam int CELL_W   = 14;
   localparam int CELL_MAX = 16383;
   localparam int DX_W     = 16;
   localparam int MAG_W    = 32;
   localparam int PROD_W   = DX_W + MAG_W;
   localparam int VAL_W    = PROD_W + 1;
   localparam int DEN_W    = 16;
   localparam int CNT_W    = 6;
   localparam int CSR_W    = 7;

   typedef enum logic [1:0] {
      OP_ANGLE_PT = 2'd0,
      OP_SPEED_PT = 2'd1,
      OP_CELL     = 2'd2,
      OP_QUERY    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_ANGLE_COUNT = 2'd0,
      CSR_SPEED_COUNT = 2'd1,
      CSR_TABLE_READY = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE, S_A_FIRST, S_A_LAST, S_A_CLAMP, S_A_READ, S_A_CMP,
      S_S_FIRST, S_S_LAST, S_S_CLAMP, S_S_READ, S_S_CMP,
      S_G_A, S_G_B, S_G_C, S_G_D, S_G_E,
      S_INF_GO, S_INF_WAIT, S_SUP_GO, S_SUP_WAIT, S_PICK,
      S_RES_GO, S_RES_WAIT, S_FINISH, S_DONE
   } ctrl_state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_RD_FIRST, CMD_RD_LAST, CMD_CLAMP, CMD_RD_PT, CMD_CMP,
      CMD_G_A, CMD_G_B, CMD_G_C, CMD_G_D, CMD_G_E,
      CMD_INF_GO, CMD_INF_WAIT, CMD_SUP_GO, CMD_SUP_WAIT, CMD_PICK,
      CMD_RES_GO, CMD_RES_WAIT, CMD_FINISH
   } cmd_op_type;

   typedef enum logic [1:0] {
      L_IDLE, L_MUL, L_DIV, L_DONE
   } lerp_state_type;

   typedef struct packed {
      logic       accept;
      logic       speed_axis;
      cmd_op_type op;
   } cmd_type;

   typedef struct packed {
      logic query;
      logic enabled;
      logic found;
      logic i_same;
      logic res_skip;
      logic lerp_done;
   } status_type;

   function automatic logic [CELL_W-1:0] sat_cell(input logic [ANG_PT_W-1:0] v);
      logic [CELL_W-1:0] r;
      if (32'(v) > CELL_MAX) r = CELL_W'(CELL_MAX);
      else r = v[CELL_W-1:0];
      return r;
   endfunction

endpackage

>>> hdl/pbsl_lerp.sv
`timescale 1ns / 1ps

module pbsl_lerp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              go,
   input  logic signed [pbsl_pkg::VAL_W-1:0] p,
   input  logic signed [pbsl_pkg::VAL_W-1:0] q,
   input  logic        [pbsl_pkg::PT_W-1:0]  x,
   input  logic        [pbsl_pkg::PT_W-1:0]  x0,
   input  logic        [pbsl_pkg::PT_W-1:0]  x1,
   output logic                              done,
   output logic signed [pbsl_pkg::VAL_W-1:0] y
);

   pbsl_pkg::lerp_state_type state_ff, state_in;
   logic [pbsl_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [pbsl_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [pbsl_pkg::MAG_W-1:0]     mcand_ff, mcand_in;
   logic [pbsl_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [pbsl_pkg::DEN_W-1:0]     rem_ff, rem_in;
   logic signed [pbsl_pkg::VAL_W-1:0] p_ff, p_in;
   logic neg_ff, neg_in, bypass_ff, bypass_in;

   logic signed [pbsl_pkg::PT_W:0]    den_s, dx_s;
   logic signed [pbsl_pkg::VAL_W-1:0] dq_s, dq_abs;
   logic [pbsl_pkg::PT_W:0]           dx_abs;
   logic [pbsl_pkg::MAG_W:0]          add_t;
   logic [pbsl_pkg::DEN_W:0]          div_t;
   logic signed [pbsl_pkg::VAL_W-1:0] quot_s;

   always_comb begin
      den_s  = $signed({1'b0, x1}) - $signed({1'b0, x0});
      dx_s   = $signed({1'b0, x}) - $signed({1'b0, x0});
      dx_abs = dx_s[pbsl_pkg::PT_W] ? (pbsl_pkg::PT_W+1)'(-dx_s) : dx_s;
      dq_s   = q - p;
      dq_abs = dq_s[pbsl_pkg::VAL_W-1] ? -dq_s : dq_s;
      add_t  = {1'b0, prod_ff[pbsl_pkg::PROD_W-1:pbsl_pkg::DX_W]}
             + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      div_t  = {rem_ff, prod_ff[pbsl_pkg::PROD_W-1]};
      quot_s = $signed({1'b0, prod_ff});
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      mcand_in  = mcand_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      p_in      = p_ff;
      neg_in    = neg_ff;
      bypass_in = bypass_ff;
      case (state_ff)
         pbsl_pkg::L_IDLE: begin
            if (go) begin
               p_in      = p;
               cnt_in    = '0;
               bypass_in = (den_s <= 0);
               neg_in    = dx_s[pbsl_pkg::PT_W] ^ dq_s[pbsl_pkg::VAL_W-1];
               den_in    = den_s[pbsl_pkg::DEN_W-1:0];
               mcand_in  = dq_abs[pbsl_pkg::MAG_W-1:0];
               prod_in   = {{pbsl_pkg::MAG_W{1'b0}}, dx_abs[pbsl_pkg::DX_W-1:0]};
               state_in  = (den_s <= 0) ? pbsl_pkg::L_DONE : pbsl_pkg::L_MUL;
            end
         end
         pbsl_pkg::L_MUL: begin
            prod_in = {add_t, prod_ff[pbsl_pkg::DX_W-1:1]};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == pbsl_pkg::CNT_W'(pbsl_pkg::DX_W - 1)) begin
               cnt_in   = '0;
               rem_in   = '0;
               state_in = pbsl_pkg::L_DIV;
            end
         end
         pbsl_pkg::L_DIV: begin
            if (div_t >= {1'b0, den_ff}) begin
               rem_in  = pbsl_pkg::DEN_W'(div_t - {1'b0, den_ff});
               prod_in = {prod_ff[pbsl_pkg::PROD_W-2:0], 1'b1};
            end else begin
               rem_in  = div_t[pbsl_pkg::DEN_W-1:0];
               prod_in = {prod_ff[pbsl_pkg::PROD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == pbsl_pkg::CNT_W'(pbsl_pkg::PROD_W - 1)) begin
               state_in = pbsl_pkg::L_DONE;
            end
         end
         pbsl_pkg::L_DONE: begin
            state_in = pbsl_pkg::L_IDLE;
         end
         default: begin
            state_in = pbsl_pkg::L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbsl_pkg::L_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff    <= cnt_in;
      prod_ff   <= prod_in;
      mcand_ff  <= mcand_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      p_ff      <= p_in;
      neg_ff    <= neg_in;
      bypass_ff <= bypass_in;
   end

   assign done = (state_ff == pbsl_pkg::L_DONE);
   assign y    = bypass_ff ? p_ff : (neg_ff ? p_ff - quot_s : p_ff + quot_s);

endmodule

>>> hdl/pbsl_datapath.sv
`timescale 1ns / 1ps

module pbsl_datapath #(
   parameter int MAX_ANGLES = 64,
   parameter int MAX_SPEEDS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pbsl_pkg::cmd_type           cmd,
   output pbsl_pkg::status_type        status,
   input  logic                        csr_write_enable,
   input  logic [1:0]                  csr_index,
   input  logic [pbsl_pkg::CSR_W-1:0]  csr_write_data,
   input  logic [1:0]                  req_opcode,
   input  logic [5:0]                  req_row_index,
   input  logic [4:0]                  req_col_index,
   input  logic [14:0]                 req_load_value,
   input  logic [13:0]                 req_wind_speed,
   input  logic signed [15:0]          req_wind_angle,
   input  logic                        req_ignore_ready,
   output logic [13:0]                 rsp_boat_speed
);

   localparam int AIW    = $clog2(MAX_ANGLES);
   localparam int SIW    = $clog2(MAX_SPEEDS);
   localparam int IW     = (AIW > SIW) ? AIW : SIW;
   localparam int GDEPTH = MAX_ANGLES * MAX_SPEEDS;
   localparam int GAW    = $clog2(GDEPTH);
   localparam int PW     = pbsl_pkg::PT_W;
   localparam int VW     = pbsl_pkg::VAL_W;
   localparam int CW     = pbsl_pkg::CELL_W;

   function automatic logic [GAW-1:0] grid_addr(input logic [AIW-1:0] r,
                                                input logic [SIW-1:0] c);
      return GAW'(32'(r) * MAX_SPEEDS + 32'(c));
   endfunction

   logic [6:0] angle_count_ff;
   logic [5:0] speed_count_ff;
   logic       ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_count_ff <= 7'd2;
         speed_count_ff <= 6'd2;
         ready_ff       <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            pbsl_pkg::CSR_ANGLE_COUNT: angle_count_ff <= csr_write_data[6:0];
            pbsl_pkg::CSR_SPEED_COUNT: speed_count_ff <= csr_write_data[5:0];
            pbsl_pkg::CSR_TABLE_READY: ready_ff       <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   logic [31:0]    a_cnt, s_cnt, a_lim, s_lim;
   logic [AIW-1:0] angle_last;
   logic [SIW-1:0] speed_last;

   always_comb begin
      a_cnt = 32'(angle_count_ff);
      s_cnt = 32'(speed_count_ff);
      if (a_cnt < 32'd2) a_lim = 32'd1;
      else if (a_cnt > 32'(MAX_ANGLES)) a_lim = 32'(MAX_ANGLES - 1);
      else a_lim = a_cnt - 32'd1;
      if (s_cnt < 32'd2) s_lim = 32'd1;
      else if (s_cnt > 32'(MAX_SPEEDS)) s_lim = 32'(MAX_SPEEDS - 1);
      else s_lim = s_cnt - 32'd1;
      angle_last = AIW'(a_lim);
      speed_last = SIW'(s_lim);
   end

   logic row_ok, col_ok, a_we, s_we, g_we;
   assign row_ok = 32'(req_row_index) < 32'(MAX_ANGLES);
   assign col_ok = 32'(req_col_index) < 32'(MAX_SPEEDS);
   assign a_we   = cmd.accept && req_opcode == pbsl_pkg::OP_ANGLE_PT && row_ok;
   assign s_we   = cmd.accept && req_opcode == pbsl_pkg::OP_SPEED_PT && col_ok;
   assign g_we   = cmd.accept && req_opcode == pbsl_pkg::OP_CELL && row_ok && col_ok;

   logic [IW-1:0]  idx_ff;
   logic [AIW-1:0] a_raddr, i1_ff, i2_ff;
   logic [SIW-1:0] s_raddr, k1_ff, k2_ff;
   logic [GAW-1:0] g_raddr;

   logic [14:0] angle_mem [MAX_ANGLES];
   logic [13:0] speed_mem [MAX_SPEEDS];
   logic [CW-1:0] grid_mem [GDEPTH];
   logic [14:0] angle_rd_ff;
   logic [13:0] speed_rd_ff;
   logic [CW-1:0] grid_rd_ff;

   always_comb begin
      case (cmd.op)
         pbsl_pkg::CMD_RD_FIRST: begin
            a_raddr = '0;
            s_raddr = '0;
         end
         pbsl_pkg::CMD_RD_LAST: begin
            a_raddr = angle_last;
            s_raddr = speed_last;
         end
         default: begin
            a_raddr = AIW'(idx_ff);
            s_raddr = SIW'(idx_ff);
         end
      endcase
      case (cmd.op)
         pbsl_pkg::CMD_G_A: g_raddr = grid_addr(i1_ff, k1_ff);
         pbsl_pkg::CMD_G_B: g_raddr = grid_addr(i2_ff, k1_ff);
         pbsl_pkg::CMD_G_C: g_raddr = grid_addr(i1_ff, k2_ff);
         default:           g_raddr = grid_addr(i2_ff, k2_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (a_we) angle_mem[AIW'(req_row_index)] <= req_load_value;
      angle_rd_ff <= angle_mem[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (s_we) speed_mem[SIW'(req_col_index)] <= pbsl_pkg::sat_cell(req_load_value);
      speed_rd_ff <= speed_mem[s_raddr];
   end

   always_ff @(posedge clock) begin
      if (g_we) begin
         grid_mem[grid_addr(AIW'(req_row_index), SIW'(req_col_index))]
            <= pbsl_pkg::sat_cell(req_load_value);
      end
      grid_rd_ff <= grid_mem[g_raddr];
   end

   // search over one axis at a time
   logic [PW-1:0] pt, ang_abs, raw_v, v1, v2, lo_pt;
   logic [IW-1:0] last_idx, lo_idx;
   logic          found;

   logic [PW-1:0] ang_raw_ff, ws_raw_ff, p0_ff, v_ff, prev_ff;
   logic [PW-1:0] ang_v_ff, ax0_ff, ax1_ff, ws_v_ff, sx0_ff, sx1_ff;
   logic [CW-1:0] cell_a_ff, cell_b_ff, cell_c_ff, cell_d_ff;
   logic signed [VW-1:0] inf_ff, sup_ff, res_ff;
   logic [CW-1:0] result_ff;

   always_comb begin
      ang_abs  = req_wind_angle[15] ? PW'(~req_wind_angle + 16'd1) : PW'(req_wind_angle);
      pt       = cmd.speed_axis ? PW'(speed_rd_ff) : PW'(angle_rd_ff);
      last_idx = cmd.speed_axis ? IW'(speed_last) : IW'(angle_last);
      raw_v    = cmd.speed_axis ? ws_raw_ff : ang_raw_ff;
      v1       = (raw_v > pt) ? pt : raw_v;
      v2       = (v1 < p0_ff) ? p0_ff : v1;
      found    = (v_ff <= pt) || (idx_ff == last_idx);
      lo_idx   = ((pt == v_ff) || (idx_ff == '0)) ? idx_ff : idx_ff - 1'b1;
      lo_pt    = (lo_idx == idx_ff) ? pt : prev_ff;
   end

   logic                 lerp_go, lerp_done;
   logic signed [VW-1:0] lerp_p, lerp_q, lerp_y;
   logic [PW-1:0]        lerp_x, lerp_x0, lerp_x1;

   always_comb begin
      lerp_go = (cmd.op == pbsl_pkg::CMD_INF_GO) || (cmd.op == pbsl_pkg::CMD_SUP_GO)
             || (cmd.op == pbsl_pkg::CMD_RES_GO);
      case (cmd.op)
         pbsl_pkg::CMD_INF_GO: begin
            lerp_p  = VW'(cell_a_ff);
            lerp_q  = VW'(cell_b_ff);
            lerp_x  = ang_v_ff;
            lerp_x0 = ax0_ff;
            lerp_x1 = ax1_ff;
         end
         pbsl_pkg::CMD_SUP_GO: begin
            lerp_p  = VW'(cell_c_ff);
            lerp_q  = VW'(cell_d_ff);
            lerp_x  = ang_v_ff;
            lerp_x0 = ax0_ff;
            lerp_x1 = ax1_ff;
         end
         default: begin
            lerp_p  = inf_ff;
            lerp_q  = sup_ff;
            lerp_x  = ws_v_ff;
            lerp_x0 = sx0_ff;
            lerp_x1 = sx1_ff;
         end
      endcase
   end

   pbsl_lerp u_lerp (
      .clock (clock),
      .reset (reset),
      .go    (lerp_go),
      .p     (lerp_p),
      .q     (lerp_q),
      .x     (lerp_x),
      .x0    (lerp_x0),
      .x1    (lerp_x1),
      .done  (lerp_done),
      .y     (lerp_y)
   );

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ang_raw_ff <= ang_abs;
         ws_raw_ff  <= PW'(req_wind_speed);
      end
      case (cmd.op)
         pbsl_pkg::CMD_RD_LAST: p0_ff <= pt;
         pbsl_pkg::CMD_CLAMP: begin
            v_ff     <= v2;
            idx_ff   <= '0;
         end
         pbsl_pkg::CMD_CMP: begin
            if (found) begin
               if (cmd.speed_axis) begin
                  ws_v_ff <= v_ff;
                  k1_ff   <= SIW'(lo_idx);
                  k2_ff   <= SIW'(idx_ff);
                  sx0_ff  <= lo_pt;
                  sx1_ff  <= pt;
               end else begin
                  ang_v_ff <= v_ff;
                  i1_ff    <= AIW'(lo_idx);
                  i2_ff    <= AIW'(idx_ff);
                  ax0_ff   <= lo_pt;
                  ax1_ff   <= pt;
               end
            end else begin
               prev_ff <= pt;
               idx_ff  <= idx_ff + 1'b1;
            end
         end
         pbsl_pkg::CMD_G_B: cell_a_ff <= grid_rd_ff;
         pbsl_pkg::CMD_G_C: cell_b_ff <= grid_rd_ff;
         pbsl_pkg::CMD_G_D: cell_c_ff <= grid_rd_ff;
         pbsl_pkg::CMD_G_E: begin
            cell_d_ff <= grid_rd_ff;
            if (i1_ff == i2_ff) begin
               inf_ff <= VW'(cell_a_ff);
               sup_ff <= VW'(cell_c_ff);
            end
         end
         pbsl_pkg::CMD_INF_WAIT: if (lerp_done) inf_ff <= lerp_y;
         pbsl_pkg::CMD_SUP_WAIT: if (lerp_done) sup_ff <= lerp_y;
         pbsl_pkg::CMD_RES_WAIT: if (lerp_done) res_ff <= lerp_y;
         pbsl_pkg::CMD_PICK: if (status.res_skip) res_ff <= inf_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_ff <= '0;
      end else if (cmd.accept && req_opcode == pbsl_pkg::OP_QUERY) begin
         result_ff <= '0;
      end else if (cmd.op == pbsl_pkg::CMD_FINISH) begin
         if (res_ff < 0) result_ff <= '0;
         else if (res_ff > VW'(pbsl_pkg::CELL_MAX)) result_ff <= CW'(pbsl_pkg::CELL_MAX);
         else result_ff <= res_ff[CW-1:0];
      end
   end

   always_comb begin
      status.query     = (req_opcode == pbsl_pkg::OP_QUERY);
      status.enabled   = ready_ff | req_ignore_ready;
      status.found     = found;
      status.i_same    = (i1_ff == i2_ff);
      status.res_skip  = (sup_ff == inf_ff) || (k1_ff == k2_ff);
      status.lerp_done = lerp_done;
   end

   assign rsp_boat_speed = result_ff;

endmodule

>>> hdl/pbsl_ctrl.sv
`timescale 1ns / 1ps

module pbsl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  pbsl_pkg::status_type status,
   output pbsl_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   pbsl_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbsl_pkg::S_IDLE: begin
            if (start && status.query) begin
               state_in = status.enabled ? pbsl_pkg::S_A_FIRST : pbsl_pkg::S_DONE;
            end
         end
         pbsl_pkg::S_A_FIRST:  state_in = pbsl_pkg::S_A_LAST;
         pbsl_pkg::S_A_LAST:   state_in = pbsl_pkg::S_A_CLAMP;
         pbsl_pkg::S_A_CLAMP:  state_in = pbsl_pkg::S_A_READ;
         pbsl_pkg::S_A_READ:   state_in = pbsl_pkg::S_A_CMP;
         pbsl_pkg::S_A_CMP:    state_in = status.found ? pbsl_pkg::S_S_FIRST : pbsl_pkg::S_A_READ;
         pbsl_pkg::S_S_FIRST:  state_in = pbsl_pkg::S_S_LAST;
         pbsl_pkg::S_S_LAST:   state_in = pbsl_pkg::S_S_CLAMP;
         pbsl_pkg::S_S_CLAMP:  state_in = pbsl_pkg::S_S_READ;
         pbsl_pkg::S_S_READ:   state_in = pbsl_pkg::S_S_CMP;
         pbsl_pkg::S_S_CMP:    state_in = status.found ? pbsl_pkg::S_G_A : pbsl_pkg::S_S_READ;
         pbsl_pkg::S_G_A:      state_in = pbsl_pkg::S_G_B;
         pbsl_pkg::S_G_B:      state_in = pbsl_pkg::S_G_C;
         pbsl_pkg::S_G_C:      state_in = pbsl_pkg::S_G_D;
         pbsl_pkg::S_G_D:      state_in = pbsl_pkg::S_G_E;
         pbsl_pkg::S_G_E:      state_in = status.i_same ? pbsl_pkg::S_PICK : pbsl_pkg::S_INF_GO;
         pbsl_pkg::S_INF_GO:   state_in = pbsl_pkg::S_INF_WAIT;
         pbsl_pkg::S_INF_WAIT: if (status.lerp_done) state_in = pbsl_pkg::S_SUP_GO;
         pbsl_pkg::S_SUP_GO:   state_in = pbsl_pkg::S_SUP_WAIT;
         pbsl_pkg::S_SUP_WAIT: if (status.lerp_done) state_in = pbsl_pkg::S_PICK;
         pbsl_pkg::S_PICK:     state_in = status.res_skip ? pbsl_pkg::S_FINISH : pbsl_pkg::S_RES_GO;
         pbsl_pkg::S_RES_GO:   state_in = pbsl_pkg::S_RES_WAIT;
         pbsl_pkg::S_RES_WAIT: if (status.lerp_done) state_in = pbsl_pkg::S_FINISH;
         pbsl_pkg::S_FINISH:   state_in = pbsl_pkg::S_DONE;
         pbsl_pkg::S_DONE:     state_in = pbsl_pkg::S_IDLE;
         default:              state_in = pbsl_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd.accept     = (state_ff == pbsl_pkg::S_IDLE) && start;
      cmd.speed_axis = 1'b0;
      cmd.op         = pbsl_pkg::CMD_NONE;
      case (state_ff)
         pbsl_pkg::S_A_FIRST:  cmd.op = pbsl_pkg::CMD_RD_FIRST;
         pbsl_pkg::S_A_LAST:   cmd.op = pbsl_pkg::CMD_RD_LAST;
         pbsl_pkg::S_A_CLAMP:  cmd.op = pbsl_pkg::CMD_CLAMP;
         pbsl_pkg::S_A_READ:   cmd.op = pbsl_pkg::CMD_RD_PT;
         pbsl_pkg::S_A_CMP:    cmd.op = pbsl_pkg::CMD_CMP;
         pbsl_pkg::S_S_FIRST: begin
            cmd.op         = pbsl_pkg::CMD_RD_FIRST;
            cmd.speed_axis = 1'b1;
         end
         pbsl_pkg::S_S_LAST: begin
            cmd.op         = pbsl_pkg::CMD_RD_LAST;
            cmd.speed_axis = 1'b1;
         end
         pbsl_pkg::S_S_CLAMP: begin
            cmd.op         = pbsl_pkg::CMD_CLAMP;
            cmd.speed_axis = 1'b1;
         end
         pbsl_pkg::S_S_READ: begin
            cmd.op         = pbsl_pkg::CMD_RD_PT;
            cmd.speed_axis = 1'b1;
         end
         pbsl_pkg::S_S_CMP: begin
            cmd.op         = pbsl_pkg::CMD_CMP;
            cmd.speed_axis = 1'b1;
         end
         pbsl_pkg::S_G_A:      cmd.op = pbsl_pkg::CMD_G_A;
         pbsl_pkg::S_G_B:      cmd.op = pbsl_pkg::CMD_G_B;
         pbsl_pkg::S_G_C:      cmd.op = pbsl_pkg::CMD_G_C;
         pbsl_pkg::S_G_D:      cmd.op = pbsl_pkg::CMD_G_D;
         pbsl_pkg::S_G_E:      cmd.op = pbsl_pkg::CMD_G_E;
         pbsl_pkg::S_INF_GO:   cmd.op = pbsl_pkg::CMD_INF_GO;
         pbsl_pkg::S_INF_WAIT: cmd.op = pbsl_pkg::CMD_INF_WAIT;
         pbsl_pkg::S_SUP_GO:   cmd.op = pbsl_pkg::CMD_SUP_GO;
         pbsl_pkg::S_SUP_WAIT: cmd.op = pbsl_pkg::CMD_SUP_WAIT;
         pbsl_pkg::S_PICK:     cmd.op = pbsl_pkg::CMD_PICK;
         pbsl_pkg::S_RES_GO:   cmd.op = pbsl_pkg::CMD_RES_GO;
         pbsl_pkg::S_RES_WAIT: cmd.op = pbsl_pkg::CMD_RES_WAIT;
         pbsl_pkg::S_FINISH:   cmd.op = pbsl_pkg::CMD_FINISH;
         default:              cmd.op = pbsl_pkg::CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbsl_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != pbsl_pkg::S_IDLE);
   assign rsp_valid = (state_ff == pbsl_pkg::S_DONE);

endmodule

>>> hdl/polar_bilinear_speed_lookup_core.sv
`timescale 1ns / 1ps

// Polar boat-speed lookup with bilinear interpolation on a non-uniform grid.
// An item is taken when start is high and busy is low. Load items (angle
// point, speed point, grid cell) are written in the accept cycle and leave
// busy low. A query raises busy and gives one result, shown for exactly one
// cycle with rsp_valid; the receiver cannot stall it and must take it then.
// A query on a table not marked ready (without ignore_ready) shows its 0 in
// the first cycle after the transfer. Otherwise latency is set by the linear
// breakpoint scan (a read and a compare per angle and speed point visited,
// one memory read port per list) and the shared shift-add multiply /
// restoring divide unit (a multiply then a divide per interpolation,
// bypassed when the interval is empty, up to three per query).
// The next transfer can be taken in the cycle after the strobe.
module polar_bilinear_speed_lookup_core #(
   parameter int MAX_ANGLES = 64,
   parameter int MAX_SPEEDS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_opcode,
   input  logic [5:0]                 req_row_index,
   input  logic [4:0]                 req_col_index,
   input  logic [14:0]                req_load_value,
   input  logic [13:0]                req_wind_speed,
   input  logic signed [15:0]         req_wind_angle,
   input  logic                       req_ignore_ready,
   output logic                       rsp_valid,
   output logic [13:0]                rsp_boat_speed,
   input  logic                       csr_write_enable,
   input  logic [1:0]                 csr_index,
   input  logic [pbsl_pkg::CSR_W-1:0] csr_write_data
);

   pbsl_pkg::cmd_type    cmd;
   pbsl_pkg::status_type status;

   pbsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   pbsl_datapath #(
      .MAX_ANGLES (MAX_ANGLES),
      .MAX_SPEEDS (MAX_SPEEDS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_opcode       (req_opcode),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_load_value   (req_load_value),
      .req_wind_speed   (req_wind_speed),
      .req_wind_angle   (req_wind_angle),
      .req_ignore_ready (req_ignore_ready),
      .rsp_boat_speed   (rsp_boat_speed)
   );

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode == pbsl_pkg::OP_QUERY |=> busy)
      else $error("query transfer did not raise busy");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode != pbsl_pkg::OP_QUERY |=> !busy && !rsp_valid)
      else $error("load transfer started a query");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

endmodule

>>> tb/pbsl_result_checker.sv
`timescale 1ns / 1ps

module pbsl_result_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [1:0]                   req_opcode,
   input  logic [5:0]                   req_row_index,
   input  logic [4:0]                   req_col_index,
   input  logic [14:0]                  req_load_value,
   input  logic [13:0]                  req_wind_speed,
   input  logic signed [15:0]           req_wind_angle,
   input  logic                         req_ignore_ready,
   input  logic                         rsp_valid,
   input  logic [13:0]                  rsp_boat_speed,
   input  logic                         csr_write_enable,
   input  logic [1:0]                   csr_index,
   input  logic [pbsl_pkg::CSR_W-1:0]   csr_write_data,
   output int                           errors,
   output int                           outstanding,
   output int                           queries_seen
);

   localparam int N_ANG = 64;
   localparam int N_SPD = 32;

   logic [14:0] angle_bp [N_ANG];
   logic [13:0] speed_bp [N_SPD];
   logic [13:0] grid [N_ANG*N_SPD];
   logic [6:0]  n_angle_reg;
   logic [5:0]  n_speed_reg;
   logic        ready_reg;
   logic [13:0] expected_speed [$];

   task automatic report_mismatch(input string what, input logic [13:0] got,
                                  input logic [13:0] want);
      $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   function automatic longint bp_value(input bit on_angle, input int i);
      return on_angle ? longint'(angle_bp[i]) : longint'(speed_bp[i]);
   endfunction

   // clamp value to list ends, return lower/upper breakpoint indices
   function automatic void find_interval(input bit on_angle, input int n, inout longint v,
                                         output int lo, output int hi);
      int i;
      if (v > bp_value(on_angle, n-1)) v = bp_value(on_angle, n-1);
      if (v < bp_value(on_angle, 0)) v = bp_value(on_angle, 0);
      for (i = 0; i < n; i++)
         if (v <= bp_value(on_angle, i)) break;
      if (i >= n) i = n - 1;
      hi = i;
      lo = (bp_value(on_angle, i) == v || i == 0) ? i : i - 1;
   endfunction

   function automatic longint blend(input longint p, input longint q, input longint x,
                                    input longint x0, input longint x1);
      longint den;
      den = x1 - x0;
      if (den <= 0) return p;
      return p + ((x - x0) * (q - p)) / den;
   endfunction

   function automatic logic [13:0] boat_speed_for(input logic [13:0] ws_in,
                                                  input logic signed [15:0] ang_in,
                                                  input logic force_it);
      longint ang, ws, a, b, c, d, inf, sup, res;
      int na, ns, i1, i2, k1, k2;
      if (!ready_reg && !force_it) return '0;
      ang = longint'(ang_in);
      if (ang < 0) ang = -ang;
      ws = longint'(ws_in);
      na = n_angle_reg < 2 ? 2 : (n_angle_reg > N_ANG ? N_ANG : n_angle_reg);
      ns = n_speed_reg < 2 ? 2 : (n_speed_reg > N_SPD ? N_SPD : n_speed_reg);
      find_interval(1'b1, na, ang, i1, i2);
      find_interval(1'b0, ns, ws, k1, k2);
      a = grid[i1*N_SPD + k1];
      b = grid[i2*N_SPD + k1];
      c = grid[i1*N_SPD + k2];
      d = grid[i2*N_SPD + k2];
      if (i1 == i2) begin
         inf = a;
         sup = c;
      end else begin
         inf = blend(a, b, ang, angle_bp[i1], angle_bp[i2]);
         sup = blend(c, d, ang, angle_bp[i1], angle_bp[i2]);
      end
      if (sup == inf || k1 == k2) res = inf;
      else res = blend(inf, sup, ws, speed_bp[k1], speed_bp[k2]);
      if (res < 0) res = 0;
      if (res > pbsl_pkg::CELL_MAX) res = pbsl_pkg::CELL_MAX;
      return res[13:0];
   endfunction

   function automatic logic [13:0] clip_cell(input logic [14:0] v);
      return (v > pbsl_pkg::CELL_MAX) ? 14'(pbsl_pkg::CELL_MAX) : v[13:0];
   endfunction

   initial begin
      errors = 0;
      outstanding = 0;
      queries_seen = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         n_angle_reg = 7'd2;
         n_speed_reg = 6'd2;
         ready_reg = 1'b0;
         expected_speed.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_speed.size() == 0) begin
               report_mismatch("unexpected result", rsp_boat_speed, '0);
            end else begin
               if (rsp_boat_speed !== expected_speed[0])
                  report_mismatch("boat_speed", rsp_boat_speed, expected_speed[0]);
               void'(expected_speed.pop_front());
            end
         end
         if (start && !busy) begin
            case (pbsl_pkg::opcode_type'(req_opcode))
               pbsl_pkg::OP_ANGLE_PT: angle_bp[req_row_index] = req_load_value;
               pbsl_pkg::OP_SPEED_PT: speed_bp[req_col_index] = clip_cell(req_load_value);
               pbsl_pkg::OP_CELL:
                  grid[req_row_index*N_SPD + req_col_index] = clip_cell(req_load_value);
               pbsl_pkg::OP_QUERY: begin
                  expected_speed.push_back(boat_speed_for(req_wind_speed, req_wind_angle,
                                                          req_ignore_ready));
                  queries_seen++;
               end
               default: ;
            endcase
         end
         if (csr_write_enable) begin
            case (csr_index)
               pbsl_pkg::CSR_ANGLE_COUNT: n_angle_reg = csr_write_data[6:0];
               pbsl_pkg::CSR_SPEED_COUNT: n_speed_reg = csr_write_data[5:0];
               pbsl_pkg::CSR_TABLE_READY: ready_reg = csr_write_data[0];
               default: ;
            endcase
         end
      end
      outstanding = expected_speed.size();
   end

endmodule

>>> tb/tb_polar_bilinear_speed_lookup_core.sv
`timescale 1ns / 1ps

module tb_polar_bilinear_speed_lookup_core;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [1:0]                 req_opcode;
   logic [5:0]                 req_row_index;
   logic [4:0]                 req_col_index;
   logic [14:0]                req_load_value;
   logic [13:0]                req_wind_speed;
   logic signed [15:0]         req_wind_angle;
   logic                       req_ignore_ready;
   logic                       rsp_valid;
   logic [13:0]                rsp_boat_speed;
   logic                       csr_write_enable;
   logic [1:0]                 csr_index;
   logic [pbsl_pkg::CSR_W-1:0] csr_write_data;
   int                         errors;
   int                         outstanding;
   int                         queries_seen;
   int                         burst_left;
   int                         loads_sent;

   polar_bilinear_speed_lookup_core dut (.*);

   pbsl_result_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("tb_polar_bilinear_speed_lookup_core: done, errors");
      $finish;
   end

   // one transfer; burst/gap shaping on the sender side
   task automatic send_item(input pbsl_pkg::opcode_type op, input logic [5:0] row,
                            input logic [4:0] col, input logic [14:0] val,
                            input logic [13:0] ws, input logic signed [15:0] ang,
                            input logic force_it);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_row_index <= row;
      req_col_index <= col;
      req_load_value <= val;
      req_wind_speed <= ws;
      req_wind_angle <= ang;
      req_ignore_ready <= force_it;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      burst_left--;
      if (op != pbsl_pkg::OP_QUERY) loads_sent++;
   endtask

   task automatic query(input logic [13:0] ws, input logic signed [15:0] ang,
                        input logic force_it);
      send_item(pbsl_pkg::OP_QUERY, 6'($urandom), 5'($urandom), 15'($urandom),
                ws, ang, force_it);
   endtask

   task automatic load(input pbsl_pkg::opcode_type op, input logic [5:0] row,
                       input logic [4:0] col, input logic [14:0] val);
      send_item(op, row, col, val, 14'($urandom), 16'($urandom), 1'($urandom));
   endtask

   task automatic settle_and_write(input logic [6:0] na, input logic [5:0] ns,
                                   input logic rdy);
      start <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= pbsl_pkg::CSR_ANGLE_COUNT;
      csr_write_data <= na;
      @(negedge clock);
      csr_index <= pbsl_pkg::CSR_SPEED_COUNT;
      csr_write_data <= {1'b0, ns};
      @(negedge clock);
      csr_index <= pbsl_pkg::CSR_TABLE_READY;
      csr_write_data <= {6'($urandom_range(0, 63)), rdy};
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // counts stay within the filled grid: up to 8 angles, or only 2 speeds
   task automatic random_counts();
      if ($urandom_range(0, 1) == 0)
         settle_and_write(7'($urandom_range(2, 8)), 6'($urandom_range(2, 32)), 1'b1);
      else
         settle_and_write(7'($urandom_range(2, 64)), 6'd2, 1'b1);
   endtask

   task automatic load_sorted_lists();
      int a;
      int s;
      a = $urandom_range(0, 300);
      for (int i = 0; i < 64; i++) begin
         load(pbsl_pkg::OP_ANGLE_PT, 6'(i), 5'($urandom), 15'(a));
         a += $urandom_range(1, 520);
      end
      s = $urandom_range(0, 200);
      for (int i = 0; i < 32; i++) begin
         load(pbsl_pkg::OP_SPEED_PT, 6'($urandom), 5'(i), 15'(s));
         s += $urandom_range(1, 600);
      end
   endtask

   task automatic random_query();
      logic [13:0] ws;
      logic signed [15:0] ang;
      ws = ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(0, 10000));
      ang = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 36000) - 18000);
      query(ws, ang, $urandom_range(0, 3) == 0);
   endtask

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 19))
            0: load(pbsl_pkg::OP_ANGLE_PT, 6'($urandom), 5'($urandom), 15'($urandom));
            1: load(pbsl_pkg::OP_SPEED_PT, 6'($urandom), 5'($urandom),
                    ($urandom_range(0, 1)) ? 15'($urandom) : 15'($urandom_range(0, 12000)));
            2, 3: load(pbsl_pkg::OP_CELL, 6'($urandom), 5'($urandom),
                       ($urandom_range(0, 5) == 0) ? 15'($urandom)
                                                   : 15'($urandom_range(0, 10000)));
            default: random_query();
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_opcode = pbsl_pkg::OP_ANGLE_PT;
      req_row_index = '0;
      req_col_index = '0;
      req_load_value = '0;
      req_wind_speed = '0;
      req_wind_angle = '0;
      req_ignore_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = pbsl_pkg::CSR_ANGLE_COUNT;
      csr_write_data = '0;
      burst_left = 0;
      loads_sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // load sorted breakpoint lists, then fill the first 8 rows and first 2 columns of the grid
      load_sorted_lists();
      for (int r = 0; r < 64; r++)
         for (int c = 0; c < 32; c++)
            if (r < 8 || c < 2)
               load(pbsl_pkg::OP_CELL, 6'(r), 5'(c),
                    ($urandom_range(0, 40) == 0) ? 15'($urandom)
                                                 : 15'($urandom_range(0, 10000)));

      // directed: not ready, bypass, extremes, exact hits
      query(14'd5000, 16'sd9000, 1'b0);
      query(14'd5000, 16'sd9000, 1'b1);
      query(14'd0, -16'sd32768, 1'b1);
      query(14'h3fff, 16'sd32767, 1'b1);
      query(14'd0, 16'sd0, 1'b1);
      settle_and_write(7'd8, 6'd32, 1'b1);
      query(14'd0, -16'sd18000, 1'b0);
      query(14'd10000, 16'sd18000, 1'b0);
      query(14'h3fff, -16'sd32768, 1'b0);
      query(14'd0, 16'sd0, 1'b0);
      load(pbsl_pkg::OP_ANGLE_PT, 6'd5, 5'd0, 15'd3000);
      load(pbsl_pkg::OP_SPEED_PT, 6'd0, 5'd8, 15'd2500);
      query(14'd2500, -16'sd3000, 1'b0);
      query(14'd2501, 16'sd3001, 1'b0);
      load(pbsl_pkg::OP_CELL, 6'd7, 5'd31, 15'h7fff);
      load(pbsl_pkg::OP_SPEED_PT, 6'd0, 5'd31, 15'h7fff);
      query(14'h3fff, 16'sd32767, 1'b0);
      load(pbsl_pkg::OP_ANGLE_PT, 6'd7, 5'd0, 15'h7fff);
      query(14'd9000, 16'sd32767, 1'b0);
      load(pbsl_pkg::OP_ANGLE_PT, 6'd3, 5'd0, 15'd0);
      query(14'd4000, 16'sd5000, 1'b1);

      settle_and_write(7'd127, 6'd2, 1'b1);
      random_phase(40);
      settle_and_write(7'd0, 6'd0, 1'b1);
      random_phase(40);
      settle_and_write(7'd2, 6'd2, 1'b0);
      random_phase(40);
      settle_and_write(7'd8, 6'd63, 1'b1);
      random_phase(40);
      for (int p = 0; p < 2; p++) begin
         random_counts();
         random_phase(30);
      end

      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      $display("covered %0d queries and %0d table writes over several count/ready settings",
               queries_seen, loads_sent);
      if (errors == 0 && outstanding == 0) begin
         $display("tb_polar_bilinear_speed_lookup_core: done, clean");
      end else begin
         $display("tb_polar_bilinear_speed_lookup_core: done, errors");
      end
      $finish;
   end

endmodule
